### hdl/scrc_pkg.sv
// types, constants and datapath commands for the solid column range clipper
// no dependencies; imported by every module of the block
package scrc_pkg;

  localparam int MAX_RANGES = 32;
  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = 11;
  localparam int VAL_W      = 12;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int SW_RESET   = 640;
  localparam int SENT_RESET = (SW_RESET > MAX_WIDTH) ? MAX_WIDTH : SW_RESET;

  typedef logic [COL_W-1:0]        col_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam val_t LEFT_START  = val_t'(-(2 ** (VAL_W - 1)));
  localparam val_t LEFT_END    = val_t'(-1);
  localparam val_t RIGHT_END   = val_t'((2 ** (VAL_W - 1)) - 1);
  localparam val_t RIGHT_RESET = val_t'(SENT_RESET);

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  typedef struct packed {
    logic opcode;
    col_t seg_first;
    col_t seg_last;
    logic solid;
  } in_word_t;

  typedef struct packed {
    logic span_valid;
    col_t span_first;
    col_t span_stop;
    logic is_last;
    logic overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_RESTART,
    DP_LOAD,
    DP_SCAN,
    DP_CHECK,
    DP_WALK,
    DP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_more;
    logic ahead;
    logic covered;
    logic walk_more;
    logic can_load;
  } dp_stat_t;

endpackage

### hdl/scrc_dpath.sv
// datapath: range list registers, span compare logic, pending and output words
// depends on scrc_pkg; driven by scrc_ctrl commands
module scrc_dpath import scrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  logic      cfg_valid_i,
  input  col_t      cfg_data_i,
  input  dp_cmd_t   cmd_i,
  output dp_stat_t  stat_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_word_t out_word_o
);

  val_t      rs_q [MAX_RANGES];
  val_t      re_q [MAX_RANGES];
  cnt_t      cnt_q;
  col_t      sw_q;
  cnt_t      ptr_q;
  idx_t      s_q;
  val_t      first_q, last_q, prev_end_q;
  logic      solid_q;
  logic      pend_valid_q;
  col_t      pend_first_q, pend_end_q;
  logic      ovf_q;
  logic      out_valid_q;
  out_word_t out_word_q;

  val_t      rd_start, rd_end;
  logic      fits_before, full;
  logic      emit_req;
  val_t      emit_a, emit_b;
  logic      finish, out_load;
  out_word_t out_next;
  col_t      sw_sat;

  assign rd_start = rs_q[ptr_q[IDX_W-1:0]];
  assign rd_end   = re_q[ptr_q[IDX_W-1:0]];
  assign full     = (cnt_q == CNT_W'(MAX_RANGES));
  assign fits_before = (last_q <= rd_start);
  assign sw_sat   = (sw_q > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : sw_q;

  always_comb begin
    stat_o.empty     = (last_q <= first_q);
    stat_o.scan_more = ((ptr_q + CNT_W'(1)) < cnt_q) && (rd_end < first_q);
    stat_o.ahead     = (first_q < rd_start);
    stat_o.covered   = (last_q <= rd_end);
    stat_o.walk_more = (ptr_q < cnt_q) && (last_q >= rd_start);
    stat_o.can_load  = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    emit_req = 1'b0;
    emit_a   = first_q;
    emit_b   = last_q;
    case (cmd_i.op)
      DP_CHECK: begin
        emit_req = stat_o.ahead;
        emit_b   = fits_before ? last_q : rd_start;
      end
      DP_WALK: begin
        emit_a = prev_end_q;
        if (stat_o.walk_more) begin
          emit_b   = rd_start;
          emit_req = (prev_end_q < rd_start);
        end else begin
          emit_b   = last_q;
          emit_req = (prev_end_q < last_q);
        end
      end
      default: ;
    endcase
  end

  assign finish   = (cmd_i.op == DP_FINISH);
  assign out_load = finish || (emit_req && pend_valid_q);

  always_comb begin
    out_next.span_valid = 1'b1;
    out_next.span_first = pend_first_q;
    out_next.span_stop  = pend_end_q;
    out_next.is_last    = 1'b0;
    out_next.overflow   = 1'b0;
    if (finish) begin
      out_next.is_last  = 1'b1;
      out_next.overflow = ovf_q;
      if (!pend_valid_q) begin
        out_next.span_valid = 1'b0;
        out_next.span_first = '0;
        out_next.span_stop  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 2; i < MAX_RANGES; i++) begin
        rs_q[i] <= '0;
        re_q[i] <= '0;
      end
      rs_q[0]      <= LEFT_START;
      re_q[0]      <= LEFT_END;
      rs_q[1]      <= RIGHT_RESET;
      re_q[1]      <= RIGHT_END;
      cnt_q        <= CNT_W'(2);
      sw_q         <= COL_W'(SW_RESET);
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        sw_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.op == DP_LOAD || finish) begin
        pend_valid_q <= 1'b0;
      end else if (emit_req) begin
        pend_valid_q <= 1'b1;
      end
      case (cmd_i.op)
        DP_RESTART: begin
          rs_q[0] <= LEFT_START;
          re_q[0] <= LEFT_END;
          rs_q[1] <= $signed({1'b0, sw_sat});
          re_q[1] <= RIGHT_END;
          cnt_q   <= CNT_W'(2);
        end
        DP_CHECK: begin
          if (stat_o.ahead && solid_q) begin
            if (!fits_before || last_q == rd_start) begin
              rs_q[s_q] <= first_q;
            end else if (!full) begin
              for (int i = 1; i < MAX_RANGES; i++) begin
                if (IDX_W'(i) > s_q) begin
                  rs_q[i] <= rs_q[i-1];
                  re_q[i] <= re_q[i-1];
                end
              end
              rs_q[s_q] <= first_q;
              re_q[s_q] <= last_q;
              cnt_q     <= cnt_q + CNT_W'(1);
            end
          end
        end
        DP_WALK: begin
          if (solid_q) begin
            if (stat_o.walk_more) begin
              for (int i = 0; i < MAX_RANGES - 1; i++) begin
                if (IDX_W'(i) > s_q) begin
                  rs_q[i] <= rs_q[i+1];
                  re_q[i] <= re_q[i+1];
                end
              end
              cnt_q <= cnt_q - CNT_W'(1);
              if (stat_o.covered) begin
                re_q[s_q] <= rd_end;
              end
            end else begin
              re_q[s_q] <= last_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_req) begin
      pend_first_q <= emit_a[COL_W-1:0];
      pend_end_q   <= emit_b[COL_W-1:0];
    end
    if (out_load) begin
      out_word_q <= out_next;
    end
    case (cmd_i.op)
      DP_LOAD: begin
        first_q <= $signed({1'b0, in_word_i.seg_first});
        last_q  <= $signed({1'b0, in_word_i.seg_last});
        solid_q <= in_word_i.solid;
        ptr_q   <= '0;
        ovf_q   <= 1'b0;
      end
      DP_SCAN: begin
        if (stat_o.scan_more) begin
          ptr_q <= ptr_q + CNT_W'(1);
        end else begin
          s_q <= ptr_q[IDX_W-1:0];
        end
      end
      DP_CHECK: begin
        prev_end_q <= rd_end;
        ptr_q      <= ptr_q + CNT_W'(1);
        if (stat_o.ahead && fits_before && solid_q && last_q != rd_start && full) begin
          ovf_q <= 1'b1;
        end
      end
      DP_WALK: begin
        if (stat_o.walk_more) begin
          if (!solid_q) begin
            ptr_q <= ptr_q + CNT_W'(1);
          end
          if (stat_o.covered) begin
            last_q <= rd_end;
          end else begin
            prev_end_q <= rd_end;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### hdl/scrc_ctrl.sv
// controller state machine: sequences scan, check, walk and finish steps
// depends on scrc_pkg; commands scrc_dpath
module scrc_ctrl import scrc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_word_t in_word_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_WALK,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_word_i.opcode == OP_ADD) begin
            cmd_o.op = DP_LOAD;
            state_d  = S_SCAN;
          end else begin
            cmd_o.op = DP_RESTART;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.empty) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.op = DP_SCAN;
          if (!stat_i.scan_more) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat_i.can_load) begin
          cmd_o.op = DP_CHECK;
          state_d  = stat_i.covered ? S_FINISH : S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.can_load) begin
          cmd_o.op = DP_WALK;
          if (!stat_i.walk_more || stat_i.covered) begin
            state_d = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (stat_i.can_load) begin
          cmd_o.op = DP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/solid_column_range_clipper.sv
// top level of the solid column range clipper
// depends on scrc_pkg, scrc_ctrl and scrc_dpath
//
// Keeps a sorted list of occluded column ranges between two sentinels. An add word
// returns every visible sub-span of [seg_first, seg_last) in column order, the last
// one marked, or a single invalid result when the span is hidden; a solid span is
// merged into the list. A clear word restarts the list from screen_width and
// returns nothing. An add word visits one range register per cycle, apart from
// the stall waits described below, first to find the span's place, then to emit
// gaps and fold bridged ranges. While the output register holds a stalled result,
// the controller waits before each check, walk and finish step. screen_width may
// be written whenever the block is idle.
module solid_column_range_clipper import scrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  col_t      cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  scrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  scrc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

### test/clip_span_checker.sv
// checker for the solid column range clipper: watches the input, output and config channels,
// predicts the visible spans of each add word and compares them with what the block returns
// depends on scrc_pkg
module clip_span_checker import scrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  col_t      cfg_data_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  col_t      width_q;
  val_t      lo_q [MAX_RANGES];
  val_t      hi_q [MAX_RANGES];
  int        used_q;
  out_word_t item_spans[$];
  out_word_t spans_due[$];

  function automatic void restart_ranges();
    int w;
    w = (int'(width_q) > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
    foreach (lo_q[i]) begin
      lo_q[i] = '0;
      hi_q[i] = '0;
    end
    lo_q[0] = LEFT_START;
    hi_q[0] = LEFT_END;
    lo_q[1] = val_t'(w);
    hi_q[1] = RIGHT_END;
    used_q = 2;
  endfunction

  function automatic void note_gap(int a, int b);
    out_word_t r;
    if (b <= a || item_spans.size() >= MAX_RANGES + 1) return;
    r = '0;
    r.span_valid = 1'b1;
    r.span_first = col_t'(a);
    r.span_stop  = col_t'(b);
    item_spans.push_back(r);
  endfunction

  function automatic void predict_spans(in_word_t w);
    int        first, last, s, n, d, i;
    bit        ovf, crunch, done;
    out_word_t r;
    first = int'(w.seg_first);
    last  = int'(w.seg_last);
    ovf = 0;
    crunch = 0;
    done = 0;
    item_spans.delete();
    if (last > first) begin
      s = 0;
      while (s + 1 < used_q && int'(hi_q[s]) < first) s++;
      if (first < int'(lo_q[s])) begin
        if (last <= int'(lo_q[s])) begin
          note_gap(first, last);
          if (w.solid) begin
            if (last == int'(lo_q[s])) begin
              lo_q[s] = val_t'(first);
            end else if (used_q >= MAX_RANGES) begin
              ovf = 1;
            end else begin
              for (i = used_q; i > s; i--) begin
                lo_q[i] = lo_q[i-1];
                hi_q[i] = hi_q[i-1];
              end
              lo_q[s] = val_t'(first);
              hi_q[s] = val_t'(last);
              used_q++;
            end
          end
          done = 1;
        end else begin
          note_gap(first, int'(lo_q[s]));
          if (w.solid) lo_q[s] = val_t'(first);
        end
      end
      if (!done && last > int'(hi_q[s])) begin
        n = s;
        while (n + 1 < used_q && last >= int'(lo_q[n+1])) begin
          note_gap(int'(hi_q[n]), int'(lo_q[n+1]));
          n++;
          if (last <= int'(hi_q[n])) begin
            last = int'(hi_q[n]);
            crunch = 1;
            break;
          end
        end
        if (!crunch) note_gap(int'(hi_q[n]), last);
        if (w.solid) begin
          hi_q[s] = val_t'(last);
          if (n != s) begin
            d = s + 1;
            for (i = n + 1; i < used_q; i++) begin
              lo_q[d] = lo_q[i];
              hi_q[d] = hi_q[i];
              d++;
            end
            used_q = d;
          end
        end
      end
    end
    if (item_spans.size() == 0) item_spans.push_back(out_word_t'('0));
    r = item_spans.pop_back();
    r.is_last  = 1'b1;
    r.overflow = ovf;
    item_spans.push_back(r);
    foreach (item_spans[j]) spans_due.push_back(item_spans[j]);
  endfunction

  function automatic void check_span(out_word_t got);
    out_word_t want;
    if (spans_due.size() == 0) begin
      if (fail_count_o < 10)
        $display("%0t: unexpected word valid=%0b first=%0d end=%0d last=%0b ovf=%0b", $time,
                 got.span_valid, got.span_first, got.span_stop, got.is_last, got.overflow);
      fail_count_o++;
      return;
    end
    want = spans_due.pop_front();
    if (got.span_valid != want.span_valid || got.span_first != want.span_first ||
        got.span_stop != want.span_stop || got.is_last != want.is_last ||
        got.overflow != want.overflow) begin
      if (fail_count_o < 10)
        $display("%0t: span mismatch expected %0b/%0d/%0d/%0b/%0b got %0b/%0d/%0d/%0b/%0b",
                 $time, want.span_valid, want.span_first, want.span_stop, want.is_last,
                 want.overflow, got.span_valid, got.span_first, got.span_stop, got.is_last,
                 got.overflow);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q = col_t'(SW_RESET);
      restart_ranges();
      spans_due.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_span(out_word_i);
      if (in_valid_i && !in_stall_i) begin
        if (in_word_i.opcode == OP_CLEAR) restart_ranges();
        else predict_spans(in_word_i);
      end
      if (cfg_valid_i && cfg_ready_i) width_q = cfg_data_i;
    end
    pending_o = spans_due.size();
  end

endmodule

### test/tb_top.sv
// top of the clipper testbench: clock, reset, directed and random span words, config writes
// depends on scrc_pkg, solid_column_range_clipper and clip_span_checker
module tb_top import scrc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 100;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  col_t      cfg_data_i;
  int        fail_count;
  int        pending;
  bit        idle_en;
  bit        hold_req;
  bit        hold_done;

  col_t      width_set [6] = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd640, 11'd96};
  int        phase_len [6] = '{90, 40, 70, 30, 110, 80};

  solid_column_range_clipper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  clip_span_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_i   (out_word_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver side: random stall, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_stall_i = idle_en && ($urandom_range(99) < 38);
      end
    end
  end

  task automatic send_word(input in_word_t w);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < 38) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i = w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic offer_span(input int first, input int last, input bit solid);
    in_word_t w;
    w = '0;
    w.opcode = OP_ADD;
    w.seg_first = col_t'(first);
    w.seg_last = col_t'(last);
    w.solid = solid;
    send_word(w);
  endtask

  task automatic offer_clear();
    in_word_t    w;
    logic [31:0] rnd;
    rnd = $urandom;
    w = rnd[$bits(in_word_t)-1:0];
    w.opcode = OP_CLEAR;
    send_word(w);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_width(input col_t w);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = w;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic in_word_t make_add(bit scatter, int cols);
    in_word_t w;
    int       a, len, cells;
    w = '0;
    w.opcode = OP_ADD;
    if ($urandom_range(99) < 8) begin
      w.seg_first = col_t'($urandom);
      w.seg_last = col_t'($urandom);
      w.solid = 1'($urandom);
    end else if (scatter) begin
      cells = (cols + 7) / 8;
      if (cells < 1) cells = 1;
      a = 8 * $urandom_range(cells - 1) + $urandom_range(2);
      len = $urandom_range(1, 4);
      w.seg_first = col_t'(a);
      w.seg_last = col_t'(a + len);
      w.solid = ($urandom_range(99) < 90);
    end else begin
      a = $urandom_range(cols + 20);
      len = ($urandom_range(3) == 0) ? $urandom_range(0, 500) : $urandom_range(1, 40);
      if (a + len > 2047) len = 2047 - a;
      w.seg_first = col_t'(a);
      w.seg_last = col_t'(a + len);
      w.solid = ($urandom_range(99) < 65);
    end
    return w;
  endfunction

  task automatic run_frames(input int count, input col_t sw, input bit want_hold);
    int cols, sent, frame_len, j;
    bit scatter;
    cols = (int'(sw) > MAX_WIDTH) ? MAX_WIDTH : int'(sw);
    sent = 0;
    while (sent < count) begin
      scatter = ($urandom_range(2) == 0);
      frame_len = scatter ? $urandom_range(50, 70) : $urandom_range(10, 40);
      offer_clear();
      for (j = 0; j < frame_len && sent < count; j++) begin
        send_word(make_add(scatter, cols));
        sent++;
        if (want_hold && sent == 40) hold_req = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty and reversed spans, then insert, extend both ways, bridge
    offer_span(0, 0, 1'b1);
    offer_span(100, 50, 1'b1);
    offer_span(100, 200, 1'b0);
    offer_span(100, 200, 1'b1);
    offer_span(300, 400, 1'b1);
    offer_span(90, 100, 1'b1);
    offer_span(200, 250, 1'b1);
    offer_span(150, 350, 1'b1);
    offer_span(100, 300, 1'b1);
    offer_span(600, 1024, 1'b1);
    offer_span(700, 2047, 1'b1);
    offer_span(0, 2047, 1'b0);
    offer_span(2047, 0, 1'b1);
    offer_span(1024, 1024, 1'b0);
    offer_clear();
    offer_span(0, 1, 1'b1);
    offer_span(639, 640, 1'b1);
    offer_span(1, 639, 1'b1);
    offer_span(0, 640, 1'b1);
    offer_span(0, 2047, 1'b0);
    offer_clear();

    foreach (width_set[p]) begin
      settle();
      write_width(width_set[p]);
      idle_en = (p != 4);
      run_frames(phase_len[p], width_set[p], p == 0);
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/scrc_pkg.sv
hdl/scrc_dpath.sv
hdl/scrc_ctrl.sv
hdl/solid_column_range_clipper.sv
test/clip_span_checker.sv
test/tb_top.sv
